// ===== hdl/lsqf_pkg.sv =====
// Shared types, constants and the solver microprogram for the quadratic fit.
// No dependencies.
package lsqf_pkg;

   localparam int MAX_POINTS  = 1024;
   localparam int SAMPLE_BITS = 12;
   localparam int FRAC_BITS   = 16;
   localparam int CNT_W       = $clog2(MAX_POINTS + 1);
   localparam int WIDE        = 128;
   localparam int PROG_LEN    = 47;
   localparam int PC_W        = $clog2(PROG_LEN);

   localparam logic [31:0] ONE_Q   = 32'(1) << FRAC_BITS;
   localparam logic [31:0] SAT_POS = 32'h7FFF_FFFF;
   localparam logic [31:0] SAT_NEG = 32'h8000_0000;

   typedef enum logic [1:0] {
      OP_ADD = 2'd0,
      OP_SUB = 2'd1,
      OP_MUL = 2'd2,
      OP_DIV = 2'd3
   } op_type;

   typedef logic [3:0] reg_idx_type;

   localparam reg_idx_type R_S1   = 4'd0;
   localparam reg_idx_type R_S2   = 4'd1;
   localparam reg_idx_type R_S3   = 4'd2;
   localparam reg_idx_type R_S4   = 4'd3;
   localparam reg_idx_type R_SY   = 4'd4;
   localparam reg_idx_type R_SXY  = 4'd5;
   localparam reg_idx_type R_SX2Y = 4'd6;
   localparam reg_idx_type R_N    = 4'd7;
   localparam reg_idx_type R_P1   = 4'd8;
   localparam reg_idx_type R_P2   = 4'd9;
   localparam reg_idx_type R_P3   = 4'd10;
   localparam reg_idx_type R_TMP  = 4'd11;
   localparam reg_idx_type R_D    = 4'd12;
   localparam reg_idx_type R_DA   = 4'd13;
   localparam reg_idx_type R_DB   = 4'd14;
   localparam reg_idx_type R_DC   = 4'd15;

   typedef struct packed {
      op_type      op;
      reg_idx_type dst;
      reg_idx_type src_a;
      reg_idx_type src_b;
   } step_type;

   typedef struct packed {
      logic   start;
      op_type op;
   } alu_cmd_type;

   // dst = src_a op src_b; cofactor expansion of D, Da, Db, Dc
   localparam step_type PROGRAM [PROG_LEN] = '{
      // cross(c1, c2)
      '{OP_MUL, R_TMP, R_S1, R_S1}, '{OP_MUL, R_P1, R_S2, R_N}, '{OP_SUB, R_P1, R_P1, R_TMP},
      '{OP_MUL, R_TMP, R_S1, R_S2}, '{OP_MUL, R_P2, R_S3, R_N}, '{OP_SUB, R_P2, R_P2, R_TMP},
      '{OP_MUL, R_TMP, R_S2, R_S2}, '{OP_MUL, R_P3, R_S3, R_S1}, '{OP_SUB, R_P3, R_P3, R_TMP},
      // D
      '{OP_MUL, R_D, R_S4, R_P1}, '{OP_MUL, R_TMP, R_S3, R_P2}, '{OP_SUB, R_D, R_D, R_TMP},
      '{OP_MUL, R_TMP, R_S2, R_P3}, '{OP_ADD, R_D, R_D, R_TMP},
      // Da
      '{OP_MUL, R_DA, R_SX2Y, R_P1}, '{OP_MUL, R_TMP, R_SXY, R_P2},
      '{OP_SUB, R_DA, R_DA, R_TMP}, '{OP_MUL, R_TMP, R_SY, R_P3}, '{OP_ADD, R_DA, R_DA, R_TMP},
      // cross(c0, c2)
      '{OP_MUL, R_TMP, R_S2, R_S1}, '{OP_MUL, R_P1, R_S3, R_N}, '{OP_SUB, R_P1, R_P1, R_TMP},
      '{OP_MUL, R_TMP, R_S2, R_S2}, '{OP_MUL, R_P2, R_S4, R_N}, '{OP_SUB, R_P2, R_P2, R_TMP},
      '{OP_MUL, R_TMP, R_S3, R_S2}, '{OP_MUL, R_P3, R_S4, R_S1}, '{OP_SUB, R_P3, R_P3, R_TMP},
      // Db (negated expansion)
      '{OP_MUL, R_DB, R_SXY, R_P2}, '{OP_MUL, R_TMP, R_SX2Y, R_P1},
      '{OP_SUB, R_DB, R_DB, R_TMP}, '{OP_MUL, R_TMP, R_SY, R_P3}, '{OP_SUB, R_DB, R_DB, R_TMP},
      // cross(c0, c1)
      '{OP_MUL, R_TMP, R_S2, R_S2}, '{OP_MUL, R_P1, R_S3, R_S1}, '{OP_SUB, R_P1, R_P1, R_TMP},
      '{OP_MUL, R_TMP, R_S2, R_S3}, '{OP_MUL, R_P2, R_S4, R_S1}, '{OP_SUB, R_P2, R_P2, R_TMP},
      '{OP_MUL, R_TMP, R_S3, R_S3}, '{OP_MUL, R_P3, R_S4, R_S2}, '{OP_SUB, R_P3, R_P3, R_TMP},
      // Dc
      '{OP_MUL, R_DC, R_SX2Y, R_P1}, '{OP_MUL, R_TMP, R_SXY, R_P2},
      '{OP_SUB, R_DC, R_DC, R_TMP}, '{OP_MUL, R_TMP, R_SY, R_P3}, '{OP_ADD, R_DC, R_DC, R_TMP}
   };

endpackage

// ===== hdl/lsqf_alu.sv =====
// Shared wide arithmetic unit: add, subtract, shift-add multiply, restoring divide.
// Depends on lsqf_pkg.
module lsqf_alu import lsqf_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  alu_cmd_type       cmd,
   input  logic [WIDE-1:0]   opa,
   input  logic [WIDE-1:0]   opb,
   output logic              done,
   output logic [WIDE-1:0]   result
);

   localparam int STEP_W = $clog2(WIDE);

   logic              run_ff;
   logic              done_ff;
   op_type            op_ff;
   logic [STEP_W-1:0] cnt_ff;
   logic [WIDE-1:0]   acc_ff;
   logic [WIDE-1:0]   sh_a_ff;
   logic [WIDE-1:0]   sh_b_ff;

   logic [WIDE-1:0]   add_x;
   logic [WIDE-1:0]   add_y;
   logic              add_sub;
   logic [WIDE:0]     sum;
   logic [WIDE-1:0]   rem_shift;

   assign rem_shift = {acc_ff[WIDE-2:0], sh_a_ff[WIDE-1]};

   always_comb begin
      add_x   = acc_ff;
      add_y   = sh_a_ff;
      add_sub = 1'b0;
      if (cmd.start) begin
         add_x   = opa;
         add_y   = opb;
         add_sub = (cmd.op == OP_SUB);
      end else if (op_ff == OP_DIV) begin
         add_x   = rem_shift;
         add_y   = sh_b_ff;
         add_sub = 1'b1;
      end
   end

   assign sum = {1'b0, add_x} + {1'b0, (add_sub ? ~add_y : add_y)} + (WIDE+1)'(add_sub);

   always_ff @(posedge clock) begin
      done_ff <= 1'b0;
      if (cmd.start) begin
         op_ff <= cmd.op;
         cnt_ff <= '0;
         case (cmd.op)
            OP_ADD, OP_SUB: begin
               acc_ff  <= sum[WIDE-1:0];
               done_ff <= 1'b1;
            end
            OP_MUL, OP_DIV: begin
               acc_ff  <= '0;
               sh_a_ff <= opa;
               sh_b_ff <= opb;
               run_ff  <= 1'b1;
            end
            default: ;
         endcase
      end else if (run_ff) begin
         cnt_ff <= cnt_ff + 1'b1;
         if (op_ff == OP_MUL) begin
            if (sh_b_ff[0]) acc_ff <= sum[WIDE-1:0];
            sh_a_ff <= sh_a_ff << 1;
            sh_b_ff <= sh_b_ff >> 1;
         end else begin
            acc_ff  <= sum[WIDE] ? sum[WIDE-1:0] : rem_shift;
            sh_a_ff <= {sh_a_ff[WIDE-2:0], sum[WIDE]};
         end
         if (cnt_ff == STEP_W'(WIDE - 1)) begin
            run_ff  <= 1'b0;
            done_ff <= 1'b1;
         end
      end
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         op_ff   <= OP_ADD;
      end
   end

   assign done   = done_ff;
   assign result = (op_ff == OP_DIV) ? sh_a_ff : acc_ff;

endmodule

// ===== hdl/least_squares_quadratic_fit.sv =====
// Quadratic least-squares fit: power-sum accumulation and a microcoded Cramer solve.
// Depends on lsqf_pkg and lsqf_alu.
// Samples not marked last: one transaction per cycle, busy stays low.
// Marked last: busy rises next cycle; the result strobe follows once the sums are loaded, the
// microprogram runs on the shared unit's bit-serial ops, then the divides (skipped when singular).
// Synchronous reset clears sums, count and sequencer; results cannot be stalled.
module least_squares_quadratic_fit import lsqf_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [11:0] req_x_sample,
   input  logic signed [11:0] req_y_sample,
   input  logic               req_last_point,
   output logic               rsp_valid,
   output logic signed [31:0] rsp_coef_a,
   output logic signed [31:0] rsp_coef_b,
   output logic signed [31:0] rsp_coef_c,
   output logic               rsp_singular
);

   typedef enum logic [8:0] {
      ST_IDLE   = 9'b000000001,
      ST_LOAD   = 9'b000000010,
      ST_FETCH  = 9'b000000100,
      ST_EXEC   = 9'b000001000,
      ST_WAIT   = 9'b000010000,
      ST_RFETCH = 9'b000100000,
      ST_PREP1  = 9'b001000000,
      ST_PREP2  = 9'b010000000,
      ST_DWAIT  = 9'b100000000
   } state_type;

   state_type state_ff, state_in;

   logic accept;
   assign accept = start && !busy;

   // accumulation pipeline
   logic [CNT_W-1:0]          count_ff;
   logic                      busy_ff;
   logic                      emit_ff;
   logic                      v1_ff, add1_ff, last1_ff;
   logic signed [SAMPLE_BITS-1:0]   x1_ff, y1_ff;
   logic signed [2*SAMPLE_BITS-1:0] xx1_ff, xy1_ff;
   logic signed [3*SAMPLE_BITS-1:0] x3, x2y;
   logic signed [4*SAMPLE_BITS-1:0] x4;
   logic signed [21:0] sum_x_ff, sum_y_ff;
   logic signed [32:0] sum_x_squared_ff, sum_xy_ff;
   logic signed [43:0] sum_x_cubed_ff, sum_x_squared_y_ff;
   logic signed [54:0] sum_x_fourth_ff;

   assign x3  = xx1_ff * x1_ff;
   assign x2y = xx1_ff * y1_ff;
   assign x4  = xx1_ff * xx1_ff;

   // sequencer
   logic [2:0]       load_ff;
   logic [PC_W-1:0]  pc_ff;
   logic [1:0]       k_ff;
   step_type         step;
   reg_idx_type      ra, rb, wa;
   logic             we;
   logic [WIDE-1:0]  wd;
   logic [WIDE-1:0]  rf_mem [16];
   logic [WIDE-1:0]  rd_a_ff, rd_b_ff;
   logic [WIDE-1:0]  load_val;
   logic [WIDE-1:0]  mag_num_ff, mag_den_ff;
   logic             neg_ff;
   logic [31:0]      coef_ff [3];
   logic             singular_ff;

   alu_cmd_type      alu_cmd;
   logic [WIDE-1:0]  alu_a, alu_b, alu_res;
   logic             alu_done;

   logic             big;
   logic [31:0]      sat_val;

   assign step = PROGRAM[pc_ff];

   always_comb begin
      case (load_ff)
         3'd0:    load_val = WIDE'(sum_x_ff);
         3'd1:    load_val = WIDE'(sum_x_squared_ff);
         3'd2:    load_val = WIDE'(sum_x_cubed_ff);
         3'd3:    load_val = WIDE'(sum_x_fourth_ff);
         3'd4:    load_val = WIDE'(sum_y_ff);
         3'd5:    load_val = WIDE'(sum_xy_ff);
         3'd6:    load_val = WIDE'(sum_x_squared_y_ff);
         default: load_val = WIDE'(count_ff);
      endcase
   end

   always_comb begin
      ra = step.src_a;
      rb = step.src_b;
      if (state_ff == ST_RFETCH) begin
         ra = R_D;
         rb = R_DA + reg_idx_type'(k_ff);
      end
      we = 1'b0;
      wa = step.dst;
      wd = alu_res;
      if (state_ff == ST_LOAD) begin
         we = 1'b1;
         wa = reg_idx_type'(load_ff);
         wd = load_val;
      end else if (state_ff == ST_WAIT && alu_done) begin
         we = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (we) rf_mem[wa] <= wd;
      rd_a_ff <= rf_mem[ra];
      rd_b_ff <= rf_mem[rb];
   end

   always_comb begin
      alu_cmd.start = (state_ff == ST_EXEC) || (state_ff == ST_PREP2);
      alu_cmd.op    = (state_ff == ST_EXEC) ? step.op : OP_DIV;
      alu_a = rd_a_ff;
      alu_b = rd_b_ff;
      if (state_ff == ST_PREP2) begin
         alu_a = (mag_num_ff << (FRAC_BITS + 1)) + mag_den_ff;
         alu_b = mag_den_ff << 1;
      end
   end

   lsqf_alu u_alu (
      .clock  (clock),
      .reset  (reset),
      .cmd    (alu_cmd),
      .opa    (alu_a),
      .opb    (alu_b),
      .done   (alu_done),
      .result (alu_res)
   );

   always_comb begin
      big = |alu_res[WIDE-1:32];
      if (neg_ff)
         sat_val = (big || alu_res[31:0] > SAT_NEG) ? SAT_NEG : (32'd0 - alu_res[31:0]);
      else
         sat_val = (big || alu_res[31]) ? SAT_POS : alu_res[31:0];
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (v1_ff && last1_ff) state_in = ST_LOAD;
         ST_LOAD:   if (load_ff == 3'd7) state_in = ST_FETCH;
         ST_FETCH:  state_in = ST_EXEC;
         ST_EXEC:   state_in = ST_WAIT;
         ST_WAIT: begin
            if (alu_done)
               state_in = (pc_ff == PC_W'(PROG_LEN - 1)) ? ST_RFETCH : ST_FETCH;
         end
         ST_RFETCH: state_in = ST_PREP1;
         ST_PREP1:  state_in = (rd_a_ff == '0) ? ST_IDLE : ST_PREP2;
         ST_PREP2:  state_in = ST_DWAIT;
         ST_DWAIT: begin
            if (alu_done) state_in = (k_ff == 2'd2) ? ST_IDLE : ST_RFETCH;
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      v1_ff    <= accept;
      add1_ff  <= accept && (count_ff < CNT_W'(MAX_POINTS));
      last1_ff <= req_last_point;
      x1_ff    <= req_x_sample;
      y1_ff    <= req_y_sample;
      xx1_ff   <= req_x_sample * req_x_sample;
      xy1_ff   <= req_x_sample * req_y_sample;
      emit_ff  <= 1'b0;
      state_ff <= state_in;

      if (accept && count_ff < CNT_W'(MAX_POINTS)) count_ff <= count_ff + 1'b1;
      if (accept && req_last_point) busy_ff <= 1'b1;

      if (v1_ff && add1_ff) begin
         sum_x_ff           <= sum_x_ff + 22'(x1_ff);
         sum_y_ff           <= sum_y_ff + 22'(y1_ff);
         sum_x_squared_ff   <= sum_x_squared_ff + 33'(xx1_ff);
         sum_xy_ff          <= sum_xy_ff + 33'(xy1_ff);
         sum_x_cubed_ff     <= sum_x_cubed_ff + 44'(x3);
         sum_x_squared_y_ff <= sum_x_squared_y_ff + 44'(x2y);
         sum_x_fourth_ff    <= sum_x_fourth_ff + 55'(x4);
      end

      case (state_ff)
         ST_IDLE: begin
            load_ff <= '0;
            pc_ff   <= '0;
            k_ff    <= '0;
         end
         ST_LOAD:  load_ff <= load_ff + 1'b1;
         ST_WAIT:  if (alu_done && pc_ff != PC_W'(PROG_LEN - 1)) pc_ff <= pc_ff + 1'b1;
         ST_PREP1: begin
            neg_ff     <= rd_a_ff[WIDE-1] ^ rd_b_ff[WIDE-1];
            mag_num_ff <= rd_b_ff[WIDE-1] ? (WIDE'(0) - rd_b_ff) : rd_b_ff;
            mag_den_ff <= rd_a_ff[WIDE-1] ? (WIDE'(0) - rd_a_ff) : rd_a_ff;
            if (rd_a_ff == '0) begin
               coef_ff[0]  <= ONE_Q;
               coef_ff[1]  <= ONE_Q;
               coef_ff[2]  <= ONE_Q;
               singular_ff <= 1'b1;
               emit_ff     <= 1'b1;
            end
         end
         ST_DWAIT: begin
            if (alu_done) begin
               coef_ff[k_ff] <= sat_val;
               singular_ff   <= 1'b0;
               k_ff          <= k_ff + 1'b1;
               if (k_ff == 2'd2) emit_ff <= 1'b1;
            end
         end
         default: ;
      endcase

      if (emit_ff) begin
         busy_ff            <= 1'b0;
         count_ff           <= '0;
         sum_x_ff           <= '0;
         sum_y_ff           <= '0;
         sum_x_squared_ff   <= '0;
         sum_xy_ff          <= '0;
         sum_x_cubed_ff     <= '0;
         sum_x_squared_y_ff <= '0;
         sum_x_fourth_ff    <= '0;
      end

      if (reset) begin
         state_ff           <= ST_IDLE;
         busy_ff            <= 1'b0;
         emit_ff            <= 1'b0;
         v1_ff              <= 1'b0;
         add1_ff            <= 1'b0;
         count_ff           <= '0;
         sum_x_ff           <= '0;
         sum_y_ff           <= '0;
         sum_x_squared_ff   <= '0;
         sum_xy_ff          <= '0;
         sum_x_cubed_ff     <= '0;
         sum_x_squared_y_ff <= '0;
         sum_x_fourth_ff    <= '0;
      end
   end

   assign busy         = busy_ff;
   assign rsp_valid    = emit_ff;
   assign rsp_coef_a   = coef_ff[0];
   assign rsp_coef_b   = coef_ff[1];
   assign rsp_coef_c   = coef_ff[2];
   assign rsp_singular = singular_ff;

endmodule

// ===== hdl/lsqf_checker.sv =====
// Port-level checks for the quadratic fit, bound to the top level.
// Depends on lsqf_pkg.
module lsqf_checker import lsqf_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        req_last_point,
   input logic        rsp_valid,
   input logic [31:0] rsp_coef_a,
   input logic [31:0] rsp_coef_b,
   input logic [31:0] rsp_coef_c,
   input logic        rsp_singular
);

   a_last_sets_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_last_point |=> busy)
      else $error("last transaction did not raise busy");

   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid && !busy)
      else $error("result strobe longer than one cycle or busy held");

   a_rsp_in_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("result outside a solve");

   a_singular_ones: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_singular |->
         rsp_coef_a == ONE_Q && rsp_coef_b == ONE_Q && rsp_coef_c == ONE_Q)
      else $error("singular result without unit coefficients");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !busy && !rsp_valid)
      else $error("not idle after reset");

endmodule

bind least_squares_quadratic_fit lsqf_checker u_lsqf_checker (
   .clock          (clock),
   .reset          (reset),
   .start          (start),
   .busy           (busy),
   .req_last_point (req_last_point),
   .rsp_valid      (rsp_valid),
   .rsp_coef_a     (rsp_coef_a),
   .rsp_coef_b     (rsp_coef_b),
   .rsp_coef_c     (rsp_coef_c),
   .rsp_singular   (rsp_singular)
);
